// ----- rtl/core/gvwbm_pkg.sv -----
// gvwbm_pkg: shared types and codes of the greedy vertex-weighted bipartite matcher
// used by gvwbm_ctrl, gvwbm_dp and the top level; depends on nothing
package gvwbm_pkg;

    localparam logic [2:0] ACT_SET_LEFT  = 3'd0;
    localparam logic [2:0] ACT_SET_RIGHT = 3'd1;
    localparam logic [2:0] ACT_ADD_EDGE  = 3'd2;
    localparam logic [2:0] ACT_MATCH     = 3'd3;
    localparam logic [2:0] ACT_QUERY     = 3'd4;

    localparam logic REG_LEFT_COUNT  = 1'b0;
    localparam logic REG_RIGHT_COUNT = 1'b1;

    localparam int IN_BITS  = 48;
    localparam int OUT_BITS = 48;

    typedef struct packed {
        logic load_in;
        logic latch_err;
        logic clr_step;
        logic clr_start;
        logic vclr_step;
        logic wr_weight;
        logic add_edge;
        logic q_init;
        logic q_read;
        logic v_rd_cur;
        logic v_mark;
        logic e_rd_scan;
        logic e_eval;
        logic e_push;
        logic sel_init;
        logic sel_rd;
        logic sel_ev;
        logic wl_rd;
        logic accum;
        logic p_rd;
        logic pe_rd;
        logic p_flip;
        logic qe_rd;
        logic qe_ev;
        logic res_load;
    } gvwbm_cmd_t;

    typedef struct packed {
        logic       err;
        logic [2:0] action;
        logic       q_empty;
        logic       visited;
        logic       k_done;
        logic       sel_done;
        logic       best_found;
        logic       walk_done;
        logic       clr_done;
        logic       out_free;
    } gvwbm_sts_t;

endpackage

// ----- rtl/core/greedy_vertex_weighted_bipartite_matcher.sv -----
// Greedy vertex-weighted bipartite matcher: one item at a time, one result per
// item. A match request first clears the visit marks of all vertices
// (MAX_LEFT + MAX_RIGHT + 1), then scans every stored edge through the
// single-port edge store for each vertex expanded; this edge scan dominates
// the time that a request takes. After reset a clearing pass over the weight
// and taken stores runs before the first item is accepted. The next item is
// taken while a result still waits.
// Depends on gvwbm_pkg, gvwbm_ctrl and gvwbm_dp.
module greedy_vertex_weighted_bipartite_matcher
    import gvwbm_pkg::*;
#(
    parameter int MAX_LEFT    = 256,
    parameter int MAX_RIGHT   = 256,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [8:0]          cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          s_tuser,  // action
    // left_vertex, right_vertex, weight_value, edge_number, zero fill
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, found_partner, partner_right, total_weight, edge_in_match, zero fill
    output logic [OUT_BITS-1:0] m_tdata
);

    gvwbm_cmd_t cmd;
    gvwbm_sts_t sts;
    logic       in_accept;

    assign in_accept = s_tvalid && s_tready;

    gvwbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .sts       (sts),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    gvwbm_dp #(
        .MAX_LEFT    (MAX_LEFT),
        .MAX_RIGHT   (MAX_RIGHT),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- rtl/core/gvwbm_ctrl.sv -----
// gvwbm_ctrl: sequencer of the matcher, issues commands to gvwbm_dp
// depends on gvwbm_pkg
module gvwbm_ctrl
    import gvwbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_accept,
    input  gvwbm_sts_t sts,
    output logic       in_ready,
    output gvwbm_cmd_t cmd
);

    localparam logic [4:0] ST_CLR   = 5'd0;
    localparam logic [4:0] ST_IDLE  = 5'd1;
    localparam logic [4:0] ST_DISP  = 5'd2;
    localparam logic [4:0] ST_VCLR  = 5'd3;
    localparam logic [4:0] ST_QINIT = 5'd4;
    localparam logic [4:0] ST_QRD   = 5'd5;
    localparam logic [4:0] ST_QCHK1 = 5'd6;
    localparam logic [4:0] ST_QCHK2 = 5'd7;
    localparam logic [4:0] ST_ERD   = 5'd8;
    localparam logic [4:0] ST_EEV   = 5'd9;
    localparam logic [4:0] ST_EPUSH = 5'd10;
    localparam logic [4:0] ST_SINIT = 5'd11;
    localparam logic [4:0] ST_SRD   = 5'd12;
    localparam logic [4:0] ST_SEV   = 5'd13;
    localparam logic [4:0] ST_WRD   = 5'd14;
    localparam logic [4:0] ST_ACC   = 5'd15;
    localparam logic [4:0] ST_PRD   = 5'd16;
    localparam logic [4:0] ST_PERD  = 5'd17;
    localparam logic [4:0] ST_PFLIP = 5'd18;
    localparam logic [4:0] ST_QERD  = 5'd19;
    localparam logic [4:0] ST_QEEV  = 5'd20;
    localparam logic [4:0] ST_DONE  = 5'd21;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                cmd.latch_err = 1'b1;
                if (sts.err)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (sts.action)
                        ACT_SET_LEFT, ACT_SET_RIGHT:
                        begin
                            cmd.wr_weight = 1'b1;
                            state_next    = ST_DONE;
                        end
                        ACT_ADD_EDGE:
                        begin
                            cmd.add_edge = 1'b1;
                            state_next   = ST_DONE;
                        end
                        ACT_MATCH:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_VCLR;
                        end
                        ACT_QUERY:
                        begin
                            state_next = ST_QERD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_VCLR:
            begin
                cmd.vclr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_QINIT;
                end
            end
            ST_QINIT:
            begin
                cmd.q_init = 1'b1;
                state_next = ST_QRD;
            end
            ST_QRD:
            begin
                if (sts.q_empty)
                begin
                    state_next = ST_SINIT;
                end
                else
                begin
                    cmd.q_read = 1'b1;
                    state_next = ST_QCHK1;
                end
            end
            ST_QCHK1:
            begin
                cmd.v_rd_cur = 1'b1;
                state_next   = ST_QCHK2;
            end
            ST_QCHK2:
            begin
                if (sts.visited)
                begin
                    state_next = ST_QRD;
                end
                else
                begin
                    cmd.v_mark = 1'b1;
                    state_next = ST_ERD;
                end
            end
            ST_ERD:
            begin
                if (sts.k_done)
                begin
                    state_next = ST_QRD;
                end
                else
                begin
                    cmd.e_rd_scan = 1'b1;
                    state_next    = ST_EEV;
                end
            end
            ST_EEV:
            begin
                cmd.e_eval = 1'b1;
                state_next = ST_EPUSH;
            end
            ST_EPUSH:
            begin
                cmd.e_push = 1'b1;
                state_next = ST_ERD;
            end
            ST_SINIT:
            begin
                cmd.sel_init = 1'b1;
                state_next   = ST_SRD;
            end
            ST_SRD:
            begin
                if (sts.sel_done)
                begin
                    state_next = sts.best_found ? ST_WRD : ST_DONE;
                end
                else
                begin
                    cmd.sel_rd = 1'b1;
                    state_next = ST_SEV;
                end
            end
            ST_SEV:
            begin
                cmd.sel_ev = 1'b1;
                state_next = ST_SRD;
            end
            ST_WRD:
            begin
                cmd.wl_rd  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_PRD;
            end
            ST_PRD:
            begin
                if (sts.walk_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.p_rd   = 1'b1;
                    state_next = ST_PERD;
                end
            end
            ST_PERD:
            begin
                cmd.pe_rd  = 1'b1;
                state_next = ST_PFLIP;
            end
            ST_PFLIP:
            begin
                cmd.p_flip = 1'b1;
                state_next = ST_PRD;
            end
            ST_QERD:
            begin
                cmd.qe_rd  = 1'b1;
                state_next = ST_QEEV;
            end
            ST_QEEV:
            begin
                cmd.qe_ev  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/gvwbm_dp.sv -----
// gvwbm_dp: datapath of the matcher with edge store, vertex stores, search queue
// and result register; depends on gvwbm_pkg, driven by gvwbm_ctrl
module gvwbm_dp
    import gvwbm_pkg::*;
#(
    parameter int MAX_LEFT    = 256,
    parameter int MAX_RIGHT   = 256,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [8:0]          cfg_wdata,
    input  logic [2:0]          in_action,
    input  logic [IN_BITS-1:0]  in_data,
    input  gvwbm_cmd_t          cmd,
    output gvwbm_sts_t          sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_BITS-1:0] out_data
);

    localparam int NV   = MAX_LEFT + MAX_RIGHT + 1;
    localparam int VW   = $clog2(NV);
    localparam int LW   = $clog2(MAX_LEFT + 1);
    localparam int RW   = $clog2(MAX_RIGHT + 1);
    localparam int KW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TW   = $clog2(MAX_EDGES + 1);
    localparam int SW   = KW + 1;
    localparam int QLEN = MAX_EDGES + 2;
    localparam int QW   = $clog2(QLEN);
    localparam int CW   = $clog2(MAX_RIGHT + 2);
    localparam int WB   = WEIGHT_BITS;
    localparam int EB   = LW + RW + 1;
    localparam logic [VW-1:0] RBASE = VW'(MAX_LEFT);
    localparam logic [VW-1:0] VLAST = VW'(NV - 1);

    // configuration and latched transaction
    logic [8:0]    left_count_reg;
    logic [8:0]    right_count_reg;
    logic [2:0]    action_reg;
    logic [8:0]    lv_reg;
    logic [8:0]    rv_reg;
    logic [15:0]   wv_reg;
    logic [9:0]    en_reg;

    logic [TW-1:0] edge_total_reg;
    logic [31:0]   weight_sum_reg;
    logic [VW-1:0] idx_reg;
    logic [QW-1:0] head_reg;
    logic [QW-1:0] tail_reg;
    logic [VW-1:0] cur_reg;
    logic [TW-1:0] k_reg;
    logic          hit_reg;
    logic [VW-1:0] t_reg;
    logic [SW-1:0] e_reg;
    logic [CW-1:0] r_reg;
    logic [RW-1:0] best_reg;
    logic [WB-1:0] bestw_reg;
    logic          err_reg;
    logic          match_reg;

    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg;

    // stores
    logic [EB-1:0] edge_mem [MAX_EDGES];
    logic [SW-1:0] pred_mem [NV];
    logic [VW-1:0] queue_mem [QLEN];
    logic          visit_mem [NV];
    logic [WB-1:0] weight_mem [NV];
    logic          taken_mem [NV];

    logic [EB-1:0] edge_rdata;
    logic [SW-1:0] pred_rdata;
    logic [VW-1:0] queue_rdata;
    logic          visit_rdata;
    logic [WB-1:0] weight_rdata;
    logic          taken_rdata;

    logic [31:0]   nl;
    logic [31:0]   nr;
    logic          lok;
    logic          rok;
    logic          full;
    logic          en_bad;
    logic          err_comb;
    logic [VW-1:0] lv_id;
    logic [VW-1:0] rv_id;
    logic [VW-1:0] rsel_id;
    logic [LW-1:0] el;
    logic [RW-1:0] er;
    logic          ef;
    logic [VW-1:0] el_id;
    logic [VW-1:0] er_id;
    logic          hit_f;
    logic          hit_r;
    logic [VW-1:0] t_comb;
    logic [31:0]   wv32;
    logic [33:0]   sum_wide;

    logic          e_we;
    logic [KW-1:0] e_waddr;
    logic [EB-1:0] e_wdata;
    logic          e_re;
    logic [KW-1:0] e_raddr;
    logic          v_we;
    logic [VW-1:0] v_waddr;
    logic          v_wdata;
    logic          v_re;
    logic [VW-1:0] v_raddr;
    logic          w_we;
    logic [VW-1:0] w_waddr;
    logic [WB-1:0] w_wdata;
    logic          w_re;
    logic [VW-1:0] w_raddr;
    logic          tk_we;
    logic [VW-1:0] tk_waddr;
    logic          tk_wdata;
    logic          q_we;
    logic [QW-1:0] q_waddr;
    logic [VW-1:0] q_wdata;
    logic          push;

    assign nl = (32'(left_count_reg) > 32'(MAX_LEFT)) ? 32'(MAX_LEFT) : 32'(left_count_reg);
    assign nr = (32'(right_count_reg) > 32'(MAX_RIGHT)) ? 32'(MAX_RIGHT)
                                                          : 32'(right_count_reg);

    assign lok    = (lv_reg != 9'd0) && (32'(lv_reg) <= nl);
    assign rok    = (rv_reg != 9'd0) && (32'(rv_reg) <= nr);
    assign full   = 32'(edge_total_reg) >= 32'(MAX_EDGES);
    assign en_bad = 32'(en_reg) >= 32'(edge_total_reg);

    always_comb
    begin
        case (action_reg)
            ACT_SET_LEFT:  err_comb = !lok;
            ACT_SET_RIGHT: err_comb = !rok;
            ACT_ADD_EDGE:  err_comb = !lok || !rok || full;
            ACT_MATCH:     err_comb = !lok;
            ACT_QUERY:     err_comb = en_bad;
            default:       err_comb = 1'b1;
        endcase
    end

    assign lv_id   = VW'(lv_reg);
    assign rv_id   = RBASE + VW'(rv_reg);
    assign rsel_id = RBASE + VW'(r_reg);

    assign el    = edge_rdata[EB-1:RW+1];
    assign er    = edge_rdata[RW:1];
    assign ef    = edge_rdata[0];
    assign el_id = VW'(el);
    assign er_id = RBASE + VW'(er);

    // forward slot is residual while unmatched, reverse slot once matched
    assign hit_f  = (el_id == cur_reg) && !ef;
    assign hit_r  = (er_id == cur_reg) && ef;
    assign t_comb = hit_f ? er_id : el_id;

    assign wv32     = 32'(wv_reg);
    assign sum_wide = 34'(weight_sum_reg) + 34'(weight_rdata) + 34'(bestw_reg);
    assign push     = cmd.e_push && hit_reg && !visit_rdata;

    // store port selection
    assign e_we    = cmd.add_edge || cmd.p_flip;
    assign e_waddr = cmd.add_edge ? edge_total_reg[KW-1:0] : e_reg[SW-1:1];
    assign e_wdata = cmd.add_edge ? {LW'(lv_reg), RW'(rv_reg), 1'b0} : {el, er, ~e_reg[0]};
    assign e_re    = cmd.e_rd_scan || cmd.pe_rd || cmd.qe_rd;
    assign e_raddr = cmd.e_rd_scan ? k_reg[KW-1:0] :
                     cmd.pe_rd     ? pred_rdata[SW-1:1] : KW'(en_reg);

    assign v_we    = cmd.vclr_step || cmd.v_mark;
    assign v_waddr = cmd.vclr_step ? idx_reg : cur_reg;
    assign v_wdata = cmd.v_mark;
    assign v_re    = cmd.v_rd_cur || cmd.e_eval || cmd.sel_rd;
    assign v_raddr = cmd.v_rd_cur ? queue_rdata : cmd.e_eval ? t_comb : rsel_id;

    assign w_we    = cmd.clr_step || cmd.wr_weight;
    assign w_waddr = cmd.clr_step ? idx_reg : (action_reg == ACT_SET_LEFT) ? lv_id : rv_id;
    assign w_wdata = cmd.clr_step ? '0 : wv32[WB-1:0];
    assign w_re    = cmd.sel_rd || cmd.wl_rd;
    assign w_raddr = cmd.wl_rd ? lv_id : rsel_id;

    assign tk_we    = cmd.clr_step || cmd.accum;
    assign tk_waddr = cmd.clr_step ? idx_reg : RBASE + VW'(best_reg);
    assign tk_wdata = cmd.accum;

    assign q_we    = cmd.q_init || push;
    assign q_waddr = cmd.q_init ? '0 : tail_reg;
    assign q_wdata = cmd.q_init ? lv_id : t_reg;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_waddr] <= e_wdata;
        end
        if (e_re)
        begin
            edge_rdata <= edge_mem[e_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pred_mem[t_reg] <= e_reg;
        end
        if (cmd.p_rd)
        begin
            pred_rdata <= pred_mem[cur_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (cmd.q_read)
        begin
            queue_rdata <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            visit_mem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            visit_rdata <= visit_mem[v_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[w_waddr] <= w_wdata;
        end
        if (w_re)
        begin
            weight_rdata <= weight_mem[w_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tk_we)
        begin
            taken_mem[tk_waddr] <= tk_wdata;
        end
        if (cmd.sel_rd)
        begin
            taken_rdata <= taken_mem[rsel_id];
        end
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
            edge_total_reg  <= '0;
            weight_sum_reg  <= '0;
            idx_reg         <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            k_reg           <= '0;
            r_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_addr == REG_LEFT_COUNT)
            begin
                left_count_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr == REG_RIGHT_COUNT)
            begin
                right_count_reg <= cfg_wdata;
            end
            if (cmd.add_edge)
            begin
                edge_total_reg <= edge_total_reg + TW'(1);
            end
            if (cmd.accum)
            begin
                weight_sum_reg <= sum_wide[33:32] != 2'b00 ? 32'hFFFF_FFFF : sum_wide[31:0];
            end
            if (cmd.clr_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.clr_step || cmd.vclr_step)
            begin
                idx_reg <= idx_reg + VW'(1);
            end
            if (cmd.q_init)
            begin
                head_reg <= '0;
                tail_reg <= QW'(1);
            end
            else
            begin
                if (cmd.q_read)
                begin
                    head_reg <= head_reg + QW'(1);
                end
                if (push)
                begin
                    tail_reg <= tail_reg + QW'(1);
                end
            end
            if (cmd.v_mark)
            begin
                k_reg <= '0;
            end
            else if (cmd.e_push)
            begin
                k_reg <= k_reg + TW'(1);
            end
            if (cmd.sel_init)
            begin
                r_reg <= CW'(1);
            end
            else if (cmd.sel_ev)
            begin
                r_reg <= r_reg + CW'(1);
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg <= in_action;
            lv_reg     <= in_data[8:0];
            rv_reg     <= in_data[17:9];
            wv_reg     <= in_data[33:18];
            en_reg     <= in_data[43:34];
            best_reg   <= '0;
            match_reg  <= 1'b0;
        end
        if (cmd.latch_err)
        begin
            err_reg <= err_comb;
        end
        if (cmd.v_rd_cur)
        begin
            cur_reg <= queue_rdata;
        end
        else if (cmd.accum)
        begin
            cur_reg <= RBASE + VW'(best_reg);
        end
        else if (cmd.p_flip)
        begin
            cur_reg <= e_reg[0] ? er_id : el_id;
        end
        if (cmd.e_eval)
        begin
            hit_reg <= hit_f || hit_r;
            t_reg   <= t_comb;
            e_reg   <= {k_reg[KW-1:0], hit_r};
        end
        else if (cmd.pe_rd)
        begin
            e_reg <= pred_rdata;
        end
        // highest weight wins, lowest number on a tie
        if (cmd.sel_ev && visit_rdata && !taken_rdata &&
            (best_reg == '0 || weight_rdata > bestw_reg))
        begin
            best_reg  <= RW'(r_reg);
            bestw_reg <= weight_rdata;
        end
        if (cmd.qe_ev)
        begin
            match_reg <= ef && el != '0 && 32'(el) <= nl && er != '0 && 32'(er) <= nr;
        end
        if (cmd.res_load)
        begin
            out_data_reg <= {4'd0, match_reg, weight_sum_reg, 9'(best_reg),
                             best_reg != '0, err_reg};
        end
    end

    assign sts.err        = err_comb;
    assign sts.action     = action_reg;
    assign sts.q_empty    = head_reg == tail_reg;
    assign sts.visited    = visit_rdata;
    assign sts.k_done     = k_reg == edge_total_reg;
    assign sts.sel_done   = 32'(r_reg) > nr;
    assign sts.best_found = best_reg != '0;
    assign sts.walk_done  = cur_reg == lv_id;
    assign sts.clr_done   = idx_reg == VLAST;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for greedy_vertex_weighted_bipartite_matcher, with a
// built-in predictor of weights, edges, search and matching state
// depends on gvwbm_pkg and the matcher rtl
module tb;
    import gvwbm_pkg::*;

    localparam int NV    = 513;
    localparam int NSLOT = 2048;
    localparam int QLEN  = 1026;
    localparam int ROFF  = 256;

    typedef struct packed {
        logic        in_match;
        logic [31:0] total;
        logic [8:0]  partner;
        logic        found;
        logic        status;
    } match_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_addr;
    logic [8:0]        cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [2:0]        s_tuser;   // action
    // left_vertex, right_vertex, weight_value, edge_number, zero fill
    logic [IN_BITS-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // status, found_partner, partner_right, total_weight, edge_in_match, zero fill
    logic [OUT_BITS-1:0] m_tdata;

    greedy_vertex_weighted_bipartite_matcher dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // graph shadow
    int unsigned   edge_from [NSLOT];
    int unsigned   edge_to   [NSLOT];
    int            edge_cap  [NSLOT];
    int            edge_flw  [NSLOT];
    int unsigned   stored_edges;
    logic [15:0]   vweight   [NV];
    bit            taken     [NV];
    bit            reached   [NV];
    int unsigned   via_edge  [NV];
    int unsigned   bfs_fifo  [QLEN];
    logic [31:0]   running_sum;
    int unsigned   left_used, right_used;

    match_result_t pending_results[$];
    int  tx_idle_pct, rx_idle_pct;
    bit  rx_hold;
    int  mismatches, items_sent, results_seen, partners_found;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #60000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAILURE");
        $finish;
    end

    function automatic match_result_t predict_result(logic [2:0] act, int unsigned lv,
                                                     int unsigned rv, logic [15:0] w,
                                                     int unsigned en);
        match_result_t r;
        int unsigned nl, nr, head, tail, cur, best, f, e, steps, t;
        bit lok, rok;
        logic [32:0] s;
        r = '0;
        nl = (left_used > 256) ? 256 : left_used;
        nr = (right_used > 256) ? 256 : right_used;
        lok = (lv >= 1) && (lv <= nl);
        rok = (rv >= 1) && (rv <= nr);
        case (act)
            ACT_SET_LEFT:  if (lok) vweight[lv] = w; else r.status = 1'b1;
            ACT_SET_RIGHT: if (rok) vweight[ROFF + rv] = w; else r.status = 1'b1;
            ACT_ADD_EDGE:
                if (!lok || !rok || stored_edges >= 1024) r.status = 1'b1;
                else
                begin
                    f = 2 * stored_edges;
                    edge_from[f] = lv;         edge_to[f] = ROFF + rv;
                    edge_cap[f] = 1;           edge_flw[f] = 0;
                    edge_from[f + 1] = ROFF + rv; edge_to[f + 1] = lv;
                    edge_cap[f + 1] = 0;       edge_flw[f + 1] = 0;
                    stored_edges++;
                end
            ACT_MATCH:
                if (!lok) r.status = 1'b1;
                else
                begin
                    foreach (reached[i]) reached[i] = 1'b0;
                    head = 0;
                    tail = 0;
                    bfs_fifo[tail++] = lv;
                    // vertices may be queued repeatedly; the last visitor wins the predecessor
                    while (head < tail)
                    begin
                        cur = bfs_fifo[head++];
                        if (cur < NV && !reached[cur])
                        begin
                            reached[cur] = 1'b1;
                            for (e = 0; e < 2 * stored_edges; e++)
                            begin
                                t = edge_to[e];
                                if (edge_from[e] == cur && edge_cap[e] > edge_flw[e] &&
                                    t < NV && !reached[t])
                                begin
                                    via_edge[t] = e;
                                    if (tail < QLEN) bfs_fifo[tail++] = t;
                                end
                            end
                        end
                    end
                    best = 0;
                    for (int unsigned i = 1; i <= nr; i++)
                        if (reached[ROFF + i] && !taken[ROFF + i] &&
                            (best == 0 || vweight[ROFF + i] > vweight[ROFF + best]))
                            best = i;
                    if (best != 0)
                    begin
                        cur = ROFF + best;
                        s = {1'b0, running_sum} + 33'(vweight[lv]) + 33'(vweight[cur]);
                        taken[cur] = 1'b1;
                        running_sum = s[32] ? 32'hFFFF_FFFF : s[31:0];
                        for (steps = 0; cur != lv && steps < NV; steps++)
                        begin
                            e = via_edge[cur] % NSLOT;
                            edge_flw[e] += 1;
                            edge_flw[e ^ 1] -= 1;
                            cur = edge_from[e];
                        end
                        r.found = 1'b1;
                        r.partner = best[8:0];
                    end
                end
            ACT_QUERY:
                if (en >= stored_edges) r.status = 1'b1;
                else
                begin
                    f = 2 * en;
                    if (edge_flw[f] > 0 && edge_from[f] >= 1 && edge_from[f] <= nl &&
                        edge_to[f] >= ROFF + 1 && edge_to[f] <= ROFF + nr)
                        r.in_match = 1'b1;
                end
            default: r.status = 1'b1;
        endcase
        r.total = running_sum;
        return r;
    endfunction

    // sender: called just after a falling edge
    task automatic send_item(logic [2:0] act, int unsigned lv, int unsigned rv,
                             logic [15:0] w, int unsigned en);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser  = act;
        s_tdata  = {4'b0, en[9:0], w, rv[8:0], lv[8:0]};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results = {pending_results,
                           predict_result(act, 32'(lv[8:0]), 32'(rv[8:0]), w,
                                          32'(en[9:0]))};
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(logic idx, int unsigned value);
        settle();
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value[8:0];
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_LEFT_COUNT) left_used = value & 32'h1FF;
        else right_used = value & 32'h1FF;
    endtask

    always @(negedge clk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        match_result_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[43], m_tdata[42:11], m_tdata[10:2], m_tdata[1], m_tdata[0]};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found) partners_found++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: exp st=%0b fnd=%0b pr=%0d tot=%0d im=%0b",
                                 results_seen, want.status, want.found, want.partner,
                                 want.total, want.in_match);
                        $display("  got st=%0b fnd=%0b pr=%0d tot=%0d im=%0b",
                                 got.status, got.found, got.partner, got.total,
                                 got.in_match);
                    end
                end
            end
        end
    end

    task automatic test_weights_and_edges();
        write_count(REG_LEFT_COUNT, 0);
        write_count(REG_RIGHT_COUNT, 0);
        send_item(ACT_SET_LEFT, 1, 1, 16'h1234, 0);      // counts zero: rejected
        send_item(ACT_MATCH, 1, 1, 0, 0);
        write_count(REG_LEFT_COUNT, 511);                // clamps to full size
        write_count(REG_RIGHT_COUNT, 256);
        send_item(ACT_SET_LEFT, 256, 0, 16'hFFFF, 0);
        send_item(ACT_SET_RIGHT, 0, 256, 16'hFFFF, 0);
        send_item(ACT_SET_LEFT, 0, 5, 16'h0001, 0);      // vertex zero
        send_item(ACT_SET_RIGHT, 3, 257, 16'h0001, 0);   // right above count
        send_item(ACT_ADD_EDGE, 256, 256, 0, 0);
        send_item(ACT_QUERY, 0, 0, 0, 0);
        send_item(ACT_QUERY, 0, 0, 0, 1023);             // out of range
        send_item(3'd5, 1, 1, 0, 0);
        send_item(3'd7, 511, 511, 16'hFFFF, 1023);
    endtask

    task automatic test_matching();
        send_item(ACT_MATCH, 256, 0, 0, 0);
        send_item(ACT_QUERY, 0, 0, 0, 0);
        send_item(ACT_MATCH, 256, 0, 0, 0);              // repeat: nothing left to take
        send_item(ACT_SET_RIGHT, 0, 1, 16'd7, 0);
        send_item(ACT_SET_RIGHT, 0, 2, 16'd7, 0);
        send_item(ACT_ADD_EDGE, 1, 2, 0, 0);
        send_item(ACT_ADD_EDGE, 1, 1, 0, 0);
        send_item(ACT_MATCH, 1, 0, 0, 0);                // tie: lowest right wins
        send_item(ACT_ADD_EDGE, 2, 1, 0, 0);
        send_item(ACT_MATCH, 2, 0, 0, 0);                // augmenting path through left 1
        send_item(ACT_QUERY, 0, 0, 0, 1);
        send_item(ACT_QUERY, 0, 0, 0, 2);
        send_item(ACT_MATCH, 1, 0, 0, 0);
    endtask

    task automatic test_lowered_counts();
        write_count(REG_LEFT_COUNT, 1);
        write_count(REG_RIGHT_COUNT, 1);
        send_item(ACT_QUERY, 0, 0, 0, 0);
        send_item(ACT_QUERY, 0, 0, 0, 3);
        send_item(ACT_MATCH, 2, 0, 0, 0);
        send_item(ACT_MATCH, 1, 0, 0, 0);
    endtask

    task automatic send_random_item(int unsigned nl, int unsigned nr);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 12)
            send_item(3'($urandom_range(7)), $urandom_range(511), $urandom_range(511),
                      16'($urandom), $urandom_range(1023));
        else if (k < 30)
            send_item(ACT_SET_LEFT, $urandom_range(nl, 1), 0, 16'($urandom), 0);
        else if (k < 45)
            send_item(ACT_SET_RIGHT, 0, $urandom_range(nr, 1), 16'($urandom), 0);
        else if (k < 65 && stored_edges < 60)
            send_item(ACT_ADD_EDGE, $urandom_range(nl, 1), $urandom_range(nr, 1), 0, 0);
        else if (k < 85 || stored_edges == 0)
            send_item(ACT_MATCH, $urandom_range(nl, 1), 0, 0, 0);
        else
            send_item(ACT_QUERY, 0, 0, 0, $urandom_range(stored_edges - 1));
    endtask

    task automatic test_random_traffic();
        int unsigned nl, nr;
        for (int mode = 0; mode < 3; mode++)
        begin
            nl = $urandom_range(12, 2);
            nr = $urandom_range(12, 2);
            write_count(REG_LEFT_COUNT, nl);
            write_count(REG_RIGHT_COUNT, nr);
            tx_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 52 : 0;
            rx_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 36 : 0;
            repeat (20) send_random_item(nl, nr);
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(negedge clk);
                rx_hold = 1'b0;
            end
            repeat (12) send_item(ACT_QUERY, 0, 0, 0, $urandom_range(stored_edges - 1));
        join
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        rx_hold = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stored_edges = 0;
        running_sum = '0;
        left_used = 0;
        right_used = 0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        partners_found = 0;
        foreach (vweight[i]) vweight[i] = '0;
        foreach (taken[i]) taken[i] = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_weights_and_edges();
        test_matching();
        test_lowered_counts();
        test_random_traffic();
        test_backpressure();

        settle();
        $display("%0d items sent, %0d results checked, %0d partners found",
                 items_sent, results_seen, partners_found);
        $display("covered weights, edges, matching, queries, count limits and stalls");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- greedy_vertex_weighted_bipartite_matcher.f -----
rtl/core/gvwbm_pkg.sv
rtl/core/gvwbm_ctrl.sv
rtl/core/gvwbm_dp.sv
rtl/core/greedy_vertex_weighted_bipartite_matcher.sv
tb/sv/tb.sv
